>>> hw/rtl/b32e_pkg.sv
// ----------------------------------------------------------------------------
// b32e_pkg
// Shared types and constants for the Bech32 string encoder.
// ----------------------------------------------------------------------------
package b32e_pkg;

    localparam int CHK_W    = 30;
    localparam int SYM_W    = 5;
    localparam int CHAR_W   = 7;
    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 2;
    localparam int LEN_W    = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_LEN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_FIRST  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_SECOND = 2'd2;

    localparam logic [CHK_W-1:0] BCH_GEN0 = 30'h3b6a57b2;
    localparam logic [CHK_W-1:0] BCH_GEN1 = 30'h26508e6d;
    localparam logic [CHK_W-1:0] BCH_GEN2 = 30'h1ea119fa;
    localparam logic [CHK_W-1:0] BCH_GEN3 = 30'h3d4233dd;
    localparam logic [CHK_W-1:0] BCH_GEN4 = 30'h2a1462b3;
    localparam logic [CHK_W-1:0] CHK_LOW_MASK = 30'h1ffffff;
    localparam logic [CHK_W-1:0] CHK_INIT = 30'd1;

    localparam logic [CHAR_W-1:0] SEP_CHAR = 7'h31;   // '1'
    localparam logic [LEN_W-1:0]  CSUM_LAST = 5'd5;   // six checksum symbols

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PFX_HI,
        ST_PFX_LO,
        ST_SEP,
        ST_DATA,
        ST_PAD,
        ST_ZERO,
        ST_CSUM
    } t_state;

    function automatic logic [CHAR_W-1:0] alpha_char(input logic [SYM_W-1:0] sym);
        logic [CHAR_W-1:0] c;
        case (sym)
            5'd0:  c = 7'h71; // q
            5'd1:  c = 7'h70; // p
            5'd2:  c = 7'h7a; // z
            5'd3:  c = 7'h72; // r
            5'd4:  c = 7'h79; // y
            5'd5:  c = 7'h39; // 9
            5'd6:  c = 7'h78; // x
            5'd7:  c = 7'h38; // 8
            5'd8:  c = 7'h67; // g
            5'd9:  c = 7'h66; // f
            5'd10: c = 7'h32; // 2
            5'd11: c = 7'h74; // t
            5'd12: c = 7'h76; // v
            5'd13: c = 7'h64; // d
            5'd14: c = 7'h77; // w
            5'd15: c = 7'h30; // 0
            5'd16: c = 7'h73; // s
            5'd17: c = 7'h33; // 3
            5'd18: c = 7'h6a; // j
            5'd19: c = 7'h6e; // n
            5'd20: c = 7'h35; // 5
            5'd21: c = 7'h34; // 4
            5'd22: c = 7'h6b; // k
            5'd23: c = 7'h68; // h
            5'd24: c = 7'h63; // c
            5'd25: c = 7'h65; // e
            5'd26: c = 7'h36; // 6
            5'd27: c = 7'h6d; // m
            5'd28: c = 7'h75; // u
            5'd29: c = 7'h61; // a
            5'd30: c = 7'h37; // 7
            5'd31: c = 7'h6c; // l
            default: c = 7'h71;
        endcase
        return c;
    endfunction

endpackage

>>> hw/rtl/b32e_in_if.sv
// ----------------------------------------------------------------------------
// b32e_in_if
// Payload byte channel into the Bech32 encoder.
// ----------------------------------------------------------------------------
interface b32e_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       final_byte;
    logic       empty_payload;

    modport source (output valid, output payload_byte, output final_byte,
                    output empty_payload, input ready);
    modport sink   (input valid, input payload_byte, input final_byte,
                    input empty_payload, output ready);
endinterface

>>> hw/rtl/b32e_out_if.sv
// ----------------------------------------------------------------------------
// b32e_out_if
// Character channel out of the Bech32 encoder.
// ----------------------------------------------------------------------------
interface b32e_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_char;
    logic       last_char;

    modport source (output valid, output out_char, output last_char, input ready);
    modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

>>> hw/rtl/bech32_string_encoder.sv
// ----------------------------------------------------------------------------
// bech32_string_encoder
// Streams payload bytes out as a Bech32 string with prefix and checksum.
// ----------------------------------------------------------------------------
// One checksum step unit is reused under a small sequencer, one symbol per
// cycle unless a character waits on the output, and the input is ready only
// while the sequencer is idle. A byte inside an open string goes through the
// transfer, one or two symbols and bookkeeping. The first item of a string
// adds a prefix of L characters (high parts, zero symbol, low parts and the
// separator). The last item adds a pad symbol if bits remain, six checksum
// steps, six characters. Characters wait while output is full and not taken.
// ----------------------------------------------------------------------------
module bech32_string_encoder #(
    parameter int MAX_PREFIX_CHARS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [b32e_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [b32e_pkg::CFG_W-1:0]      i_cfg_data,
    b32e_in_if.sink                         i_in,
    b32e_out_if.source                      o_out
);
    import b32e_pkg::*;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PREFIX_CHARS);

    t_state r_state, n_state;

    logic [LEN_W-1:0]     r_pfx_len;
    logic [CFG_W-1:0]     r_pfx_first;
    logic [CFG_W-1:0]     r_pfx_second;

    logic [CHK_W-1:0]     r_chk, n_chk;
    logic [3:0]           r_store, n_store;
    logic [2:0]           r_cnt, n_cnt;
    logic                 r_open, n_open;
    logic [11:0]          r_acc, n_acc;
    logic [3:0]           r_bits, n_bits;
    logic [LEN_W-1:0]     r_idx, n_idx;
    logic [LEN_W-1:0]     r_len, n_len;
    logic [7:0]           r_byte, n_byte;
    logic                 r_fin, n_fin;
    logic                 r_empty, n_empty;

    logic                 r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]    r_out_char, n_out_char;
    logic                 r_out_last, n_out_last;

    logic                 in_xfer;
    logic                 slot;
    logic [127:0]         pfx_all;
    logic [7:0]           pfx_char;
    logic [SYM_W-1:0]     step_sym;
    logic [CHK_W-1:0]     step_out;
    logic [SYM_W-1:0]     data_sym;
    logic [SYM_W-1:0]     pad_sym;
    logic [2:0]           data_sh;
    logic [3:0]           keep_mask;
    logic [LEN_W-1:0]     len_clamped;

    assign in_xfer   = i_in.valid && i_in.ready;
    assign slot      = !r_out_valid || o_out.ready;
    assign pfx_all   = {r_pfx_second, r_pfx_first};
    assign pfx_char  = pfx_all[{r_idx[3:0], 3'b000} +: 8];
    assign data_sh   = 3'(r_bits - 4'd5);
    assign data_sym  = SYM_W'(r_acc >> data_sh);
    assign pad_sym   = SYM_W'({1'b0, r_store} << (3'd5 - r_cnt));
    assign keep_mask = ~(4'hf << r_bits[2:0]);
    assign len_clamped = (r_pfx_len > MAX_LEN) ? MAX_LEN : r_pfx_len;

    assign i_in.ready      = (r_state == ST_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.out_char  = r_out_char;
    assign o_out.last_char = r_out_last;

    b32e_bch_step u_step (
        .i_chk (r_chk),
        .i_sym (step_sym),
        .o_chk (step_out)
    );

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pfx_len    <= LEN_W'(1);
            r_pfx_first  <= '0;
            r_pfx_second <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PREFIX_LEN:    r_pfx_len    <= i_cfg_data[LEN_W-1:0];
                CFG_PREFIX_FIRST:  r_pfx_first  <= i_cfg_data;
                CFG_PREFIX_SECOND: r_pfx_second <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (!r_open) begin
                        n_state = ST_PFX_HI;
                    end else if (i_in.empty_payload) begin
                        n_state = ST_PAD;
                    end else begin
                        n_state = ST_DATA;
                    end
                end
            end
            ST_PFX_HI: begin
                if (r_idx >= r_len) begin
                    n_state = ST_PFX_LO;
                end
            end
            ST_PFX_LO: begin
                if (r_idx >= r_len) begin
                    n_state = ST_SEP;
                end
            end
            ST_SEP: begin
                if (slot) begin
                    n_state = r_empty ? ST_PAD : ST_DATA;
                end
            end
            ST_DATA: begin
                if (r_bits < 4'd5) begin
                    n_state = r_fin ? ST_PAD : ST_IDLE;
                end
            end
            ST_PAD: begin
                if (!(r_cnt inside {[3'd1:3'd4]}) || slot) begin
                    n_state = ST_ZERO;
                end
            end
            ST_ZERO: begin
                if (r_idx == CSUM_LAST) begin
                    n_state = ST_CSUM;
                end
            end
            ST_CSUM: begin
                if (slot && r_idx == CSUM_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_chk       = r_chk;
        n_store     = r_store;
        n_cnt       = r_cnt;
        n_open      = r_open;
        n_acc       = r_acc;
        n_bits      = r_bits;
        n_idx       = r_idx;
        n_len       = r_len;
        n_byte      = r_byte;
        n_fin       = r_fin;
        n_empty     = r_empty;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        step_sym    = '0;

        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_byte  = i_in.payload_byte;
                    n_fin   = i_in.final_byte;
                    n_empty = i_in.empty_payload;
                    n_idx   = '0;
                    n_acc   = {r_store, i_in.payload_byte};
                    n_bits  = {1'b0, r_cnt} + 4'd8;
                    if (!r_open) begin
                        n_chk   = CHK_INIT;
                        n_store = '0;
                        n_cnt   = '0;
                        n_len   = len_clamped;
                    end
                end
            end
            ST_PFX_HI: begin
                if (r_idx >= r_len) begin
                    step_sym = '0;
                    n_chk    = step_out;
                    n_idx    = '0;
                end else if (slot) begin
                    step_sym    = {2'b00, pfx_char[7:5]};
                    n_chk       = step_out;
                    n_out_valid = 1'b1;
                    n_out_char  = pfx_char[CHAR_W-1:0];
                    n_out_last  = 1'b0;
                    n_idx       = r_idx + 1'b1;
                end
            end
            ST_PFX_LO: begin
                if (r_idx < r_len) begin
                    step_sym = pfx_char[SYM_W-1:0];
                    n_chk    = step_out;
                    n_idx    = r_idx + 1'b1;
                end
            end
            ST_SEP: begin
                if (slot) begin
                    n_out_valid = 1'b1;
                    n_out_char  = SEP_CHAR;
                    n_out_last  = 1'b0;
                    n_open      = 1'b1;
                    n_acc       = {r_store, r_byte};
                    n_bits      = {1'b0, r_cnt} + 4'd8;
                end
            end
            ST_DATA: begin
                if (r_bits >= 4'd5) begin
                    if (slot) begin
                        step_sym    = data_sym;
                        n_chk       = step_out;
                        n_out_valid = 1'b1;
                        n_out_char  = alpha_char(data_sym);
                        n_out_last  = 1'b0;
                        n_bits      = r_bits - 4'd5;
                    end
                end else begin
                    n_store = r_acc[3:0] & keep_mask;
                    n_cnt   = r_bits[2:0];
                end
            end
            ST_PAD: begin
                n_idx = '0;
                if (r_cnt inside {[3'd1:3'd4]}) begin
                    if (slot) begin
                        step_sym    = pad_sym;
                        n_chk       = step_out;
                        n_out_valid = 1'b1;
                        n_out_char  = alpha_char(pad_sym);
                        n_out_last  = 1'b0;
                    end
                end
            end
            ST_ZERO: begin
                step_sym = '0;
                n_chk    = (r_idx == CSUM_LAST) ? (step_out ^ CHK_INIT) : step_out;
                n_idx    = (r_idx == CSUM_LAST) ? '0 : r_idx + 1'b1;
            end
            ST_CSUM: begin
                if (slot) begin
                    n_out_valid = 1'b1;
                    n_out_char  = alpha_char(r_chk[CHK_W-1 -: SYM_W]);
                    n_out_last  = (r_idx == CSUM_LAST);
                    n_chk       = {r_chk[CHK_W-SYM_W-1:0], {SYM_W{1'b0}}};
                    n_idx       = r_idx + 1'b1;
                    if (r_idx == CSUM_LAST) begin
                        n_chk   = CHK_INIT;
                        n_store = '0;
                        n_cnt   = '0;
                        n_open  = 1'b0;
                        n_idx   = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_chk       <= CHK_INIT;
            r_store     <= '0;
            r_cnt       <= '0;
            r_open      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_chk       <= n_chk;
            r_store     <= n_store;
            r_cnt       <= n_cnt;
            r_open      <= n_open;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc      <= n_acc;
        r_bits     <= n_bits;
        r_len      <= n_len;
        r_byte     <= n_byte;
        r_fin      <= n_fin;
        r_empty    <= n_empty;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

endmodule

>>> hw/rtl/b32e_bch_step.sv
// ----------------------------------------------------------------------------
// b32e_bch_step
// One step of the 30-bit BCH checksum: shift in a 5-bit symbol.
// ----------------------------------------------------------------------------
module b32e_bch_step (
    input  logic [b32e_pkg::CHK_W-1:0] i_chk,
    input  logic [b32e_pkg::SYM_W-1:0] i_sym,
    output logic [b32e_pkg::CHK_W-1:0] o_chk
);
    import b32e_pkg::*;

    logic [SYM_W-1:0] top;
    logic [CHK_W-1:0] base;

    assign top  = i_chk[CHK_W-1 -: SYM_W];
    assign base = {i_chk[CHK_W-SYM_W-1:0], i_sym};

    assign o_chk = base
                 ^ (top[0] ? BCH_GEN0 : '0)
                 ^ (top[1] ? BCH_GEN1 : '0)
                 ^ (top[2] ? BCH_GEN2 : '0)
                 ^ (top[3] ? BCH_GEN3 : '0)
                 ^ (top[4] ? BCH_GEN4 : '0);
endmodule

>>> test/bech32_string_encoder_checker.sv
// ----------------------------------------------------------------------------
// bech32_string_encoder_checker
// Watches the config port and both channels of the Bech32 string encoder.
// Each byte transfer is run through a bit-exact software encoder.
// Each character transfer is compared with the oldest predicted character.
// ----------------------------------------------------------------------------
module bech32_string_encoder_checker #(
    parameter int MAX_PREFIX_CHARS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [b32e_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [b32e_pkg::CFG_W-1:0]     i_cfg_data,
    b32e_in_if                             i_in_ch,
    b32e_out_if                            i_out_ch,
    output int                             o_fail_count,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import b32e_pkg::*;

    localparam logic [8*32-1:0] ALPHABET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_char;

    t_char              exp_chars[$];
    int                 fail_count = 0;

    logic [LEN_W-1:0]   pfx_len;
    logic [CFG_W-1:0]   pfx_lo;
    logic [CFG_W-1:0]   pfx_hi;
    logic [CHK_W-1:0]   chk;
    logic [3:0]         store;
    logic [2:0]         nbits;
    logic               open_str;

    assign o_fail_count = fail_count;

    function automatic logic [CHK_W-1:0] poly_step(input logic [CHK_W-1:0] c,
                                                   input logic [SYM_W-1:0] s);
        logic [4:0]       top;
        logic [CHK_W-1:0] r;
        top = c[29:25];
        r = {c[24:0], s};
        if (top[0]) r = r ^ BCH_GEN0;
        if (top[1]) r = r ^ BCH_GEN1;
        if (top[2]) r = r ^ BCH_GEN2;
        if (top[3]) r = r ^ BCH_GEN3;
        if (top[4]) r = r ^ BCH_GEN4;
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] sym_char(input logic [SYM_W-1:0] s);
        logic [7:0] b;
        b = ALPHABET[8*(31-int'(s)) +: 8];
        return b[CHAR_W-1:0];
    endfunction

    function automatic logic [7:0] pfx_byte(input int i);
        if (i < 8) begin
            return pfx_lo[8*i +: 8];
        end
        return pfx_hi[8*(i-8) +: 8];
    endfunction

    task automatic push_char(input logic [CHAR_W-1:0] c, input logic last);
        t_char e;
        e.ch = c;
        e.last = last;
        exp_chars.push_back(e);
    endtask

    task automatic push_symbol(input logic [SYM_W-1:0] s);
        chk = poly_step(chk, s);
        push_char(sym_char(s), 1'b0);
    endtask

    task automatic encode_item(input logic [7:0] b, input logic fin, input logic is_empty);
        int               len;
        int               bits;
        logic [7:0]       pc;
        logic [11:0]      acc;
        logic [11:0]      sh;
        logic [CHK_W-1:0] modv;
        logic [CHK_W-1:0] sh30;
        if (!open_str) begin
            len = (pfx_len > MAX_PREFIX_CHARS) ? MAX_PREFIX_CHARS : int'(pfx_len);
            chk = CHK_INIT;
            store = '0;
            nbits = '0;
            for (int i = 0; i < len; i++) begin
                pc = pfx_byte(i);
                chk = poly_step(chk, {2'b00, pc[7:5]});
                push_char(pc[CHAR_W-1:0], 1'b0);
            end
            chk = poly_step(chk, '0);
            for (int i = 0; i < len; i++) begin
                pc = pfx_byte(i);
                chk = poly_step(chk, pc[4:0]);
            end
            push_char(SEP_CHAR, 1'b0);
            open_str = 1'b1;
        end

        if (!is_empty) begin
            acc = {store, b};
            bits = int'(nbits) + 8;
            while (bits >= 5) begin
                bits = bits - 5;
                sh = acc >> bits;
                push_symbol(sh[4:0]);
            end
            store = acc[3:0] & 4'((1 << bits) - 1);
            nbits = 3'(bits);
        end

        if (is_empty || fin) begin
            if (nbits != 0) begin
                sh = {8'd0, store} << (5 - int'(nbits));
                push_symbol(sh[4:0]);
            end
            repeat (6) chk = poly_step(chk, '0);
            modv = chk ^ CHK_INIT;
            for (int i = 0; i < 6; i++) begin
                sh30 = modv >> (5 * (5 - i));
                push_char(sym_char(sh30[4:0]), i == 5);
            end
            chk = CHK_INIT;
            store = '0;
            nbits = '0;
            open_str = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        t_char want;
        if (!i_rst_n) begin
            pfx_len = LEN_W'(1);
            pfx_lo = '0;
            pfx_hi = '0;
            chk = CHK_INIT;
            store = '0;
            nbits = '0;
            open_str = 1'b0;
            exp_chars.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PREFIX_LEN:    pfx_len = i_cfg_data[LEN_W-1:0];
                    CFG_PREFIX_FIRST:  pfx_lo = i_cfg_data;
                    CFG_PREFIX_SECOND: pfx_hi = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_ch.valid && i_in_ch.ready) begin
                encode_item(i_in_ch.payload_byte, i_in_ch.final_byte, i_in_ch.empty_payload);
            end
            if (i_out_ch.valid && i_out_ch.ready) begin
                if (exp_chars.size() == 0) begin
                    if (fail_count < 10) begin
                        $display("%0t: unexpected char transfer %h last %b", $realtime,
                                 i_out_ch.out_char, i_out_ch.last_char);
                    end
                    fail_count++;
                end else begin
                    want = exp_chars.pop_front();
                    if (want.ch !== i_out_ch.out_char || want.last !== i_out_ch.last_char) begin
                        if (fail_count < 10) begin
                            $display("%0t: char mismatch: expected %h last %b, got %h last %b",
                                     $realtime, want.ch, want.last,
                                     i_out_ch.out_char, i_out_ch.last_char);
                        end
                        fail_count++;
                    end
                end
            end
        end
        o_pending <= exp_chars.size();
    end

endmodule

>>> test/bech32_string_encoder_tb.sv
// ----------------------------------------------------------------------------
// bech32_string_encoder_tb
// Drives the Bech32 string encoder with directed and random payload strings
// under several prefix settings and handshake pacing modes, including a long
// output hold-off. Checking is done by the checker instance beside the DUT.
// ----------------------------------------------------------------------------
module bech32_string_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import b32e_pkg::*;

    localparam int MAX_PFX         = 16;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_CYCLES     = 400;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int NUM_PHASES      = 8;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_CYCLES    = 20;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum int {
        PACE_FREE,
        PACE_TX,
        PACE_RX,
        PACE_BOTH
    } t_pace;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    b32e_in_if  in_ch();
    b32e_out_if out_ch();

    int fail_count;
    int pending;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    bit rx_hold_req = 1'b0;
    int quiet_cycles = 0;
    int items_sent = 0;

    bech32_string_encoder #(
        .MAX_PREFIX_CHARS(MAX_PFX)
    ) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_in      (in_ch),
        .o_out     (out_ch)
    );

    bech32_string_encoder_checker #(
        .MAX_PREFIX_CHARS(MAX_PFX)
    ) i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_ch     (in_ch),
        .i_out_ch    (out_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int hold_cnt;
        hold_cnt = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cnt != 0) begin
                hold_cnt--;
                out_ch.ready <= 1'b0;
            end else if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_cnt = HOLD_CYCLES;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input logic [7:0] b, input logic fin, input logic is_empty);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.payload_byte <= b;
        in_ch.final_byte <= fin;
        in_ch.empty_payload <= is_empty;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= d;
        @(posedge i_clk);
    endtask

    // upper bits of the length word are junk; an unused index is written too
    task automatic set_prefix(input logic [LEN_W-1:0] len, input logic [CFG_W-1:0] first,
                              input logic [CFG_W-1:0] second);
        logic [CFG_W-1:0] d;
        d = {$urandom, $urandom};
        d[LEN_W-1:0] = len;
        write_reg(CFG_PREFIX_LEN, d);
        write_reg(CFG_PREFIX_FIRST, first);
        write_reg(CFG_PREFIX_SECOND, second);
        write_reg(CFG_UNUSED, {$urandom, $urandom});
        cfg_we <= 1'b0;
    endtask

    task automatic random_prefix();
        logic [LEN_W-1:0] len;
        logic [CFG_W-1:0] lo;
        logic [CFG_W-1:0] hi;
        case ($urandom_range(9))
            0: len = 5'd0;
            1: len = 5'd16;
            2: len = 5'd31;
            3: len = 5'd1;
            4: len = LEN_W'($urandom_range(17, 30));
            default: len = LEN_W'($urandom_range(1, 16));
        endcase
        if ($urandom_range(1) == 0) begin
            for (int i = 0; i < 8; i++) begin
                lo[8*i +: 8] = 8'h61 + 8'($urandom_range(25));
                hi[8*i +: 8] = 8'h61 + 8'($urandom_range(25));
            end
        end else begin
            lo = {$urandom, $urandom};
            hi = {$urandom, $urandom};
        end
        set_prefix(len, lo, hi);
    endtask

    task automatic set_pace(input t_pace p);
        case (p)
            PACE_FREE: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            PACE_TX:   begin tx_idle_pct = 49; rx_stall_pct = 0;  end
            PACE_RX:   begin tx_idle_pct = 0;  rx_stall_pct = 49; end
            default:   begin tx_idle_pct = 23; rx_stall_pct = 23; end
        endcase
    endtask

    task automatic send_string(input int nbytes, input bit end_empty);
        if (nbytes == 0) begin
            send_item(8'($urandom), 1'($urandom), 1'b1);
        end else begin
            for (int k = 0; k < nbytes; k++) begin
                send_item(8'($urandom), (k == nbytes - 1) && !end_empty, 1'b0);
            end
            if (end_empty) send_item(8'($urandom), 1'($urandom), 1'b1);
        end
    endtask

    initial begin
        int start;
        int r;
        cfg_we <= 1'b0;
        cfg_idx <= '0;
        cfg_data <= '0;
        in_ch.valid <= 1'b0;
        in_ch.payload_byte <= '0;
        in_ch.final_byte <= 1'b0;
        in_ch.empty_payload <= 1'b0;
        i_rst_n <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset prefix: one NUL character
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h80, 1'b0, 1'b0);
        send_item(8'h01, 1'b0, 1'b0);
        send_item(8'h7f, 1'b1, 1'b0);
        send_item(8'haa, 1'b1, 1'b0);
        send_item(8'h55, 1'b0, 1'b0);
        send_item(8'hff, 1'b1, 1'b1);

        wait_idle();
        set_prefix(5'd0, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hc3, 1'b1, 1'b0);

        wait_idle();
        set_prefix(5'd16, 64'hff80_7f61_e2a0_0162, 64'h8171_7a39_ff00_6362);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h12, 1'b0, 1'b0);

        // new prefix while a string is still open
        wait_idle();
        set_prefix(5'd31, 64'h6867_6665_6463_6261, 64'h706f_6e6d_6c6b_6a69);
        send_item(8'h34, 1'b1, 1'b0);
        send_item(8'h56, 1'b0, 1'b1);
        send_item(8'h78, 1'b1, 1'b0);

        wait_idle();
        set_prefix(5'd17, 64'h6f6e_6d6c_6b6a_6362, 64'h7a79_7877_7675_7473);
        send_item(8'h9a, 1'b0, 1'b0);
        send_item(8'hbc, 1'b0, 1'b0);
        send_item(8'hde, 1'b1, 1'b0);

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            random_prefix();
            set_pace(t_pace'(p % 4));
            if (p == 4) rx_hold_req = 1'b1;
            start = items_sent;
            while (items_sent - start < ITEMS_PER_PHASE) begin
                r = $urandom_range(19);
                if (r < 2) begin
                    send_string(0, 1'b0);
                end else if (r == 2) begin
                    send_string($urandom_range(20, 40), $urandom_range(4) == 0);
                end else begin
                    send_string($urandom_range(1, 10), $urandom_range(4) == 0);
                end
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
